// ===== rtl/julian_calendar_day_number_convert_top_macros.svh =====
// ----------------------------------------------------------------------------
// julian_calendar_day_number_convert_top_macros.svh
// assertion macros for the julian day number converter
// ----------------------------------------------------------------------------
`ifndef JULIAN_CALENDAR_DAY_NUMBER_CONVERT_TOP_MACROS_SVH
`define JULIAN_CALENDAR_DAY_NUMBER_CONVERT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define JCDN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jcdn assertion failed");
`define JCDN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jcdn implication failed");
`else
`define JCDN_ASSERT(lbl, clk, rst_n, prop)
`define JCDN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/jcdn_pkg.sv =====
// ----------------------------------------------------------------------------
// jcdn_pkg
// types, constants and tables shared by the julian day number converter
// ----------------------------------------------------------------------------
package jcdn_pkg;

  localparam int unsigned YearW  = 15;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DnW    = 23;

  localparam int unsigned CycW   = 15;
  localparam int unsigned BaseW  = 24;
  localparam int unsigned QuartW = 25;
  localparam int unsigned TermW  = 9;
  localparam int unsigned UW     = 26;
  localparam int unsigned RecipW = 26;
  localparam int unsigned ProdW  = UW + RecipW;
  localparam int unsigned OffW   = 9;
  localparam int unsigned SpanW  = 4;

  localparam int unsigned RecipShift = 36;
  localparam longint unsigned RecipMul =
    ((longint'(1) << RecipShift) + 64'd1460) / 64'd1461;

  localparam int DnOffset = 1524;
  localparam int CycBias  = 4 * DnOffset - 489;
  localparam int YearBias = 4716;
  localparam int DnMax    = 2 ** DnW - 1;
  localparam int YearMax  = 2 ** (YearW - 1) - 1;
  localparam int YearMin  = -(2 ** (YearW - 1));

  localparam int unsigned NumEdges = 15;

  // smallest offset in the march-based year that reaches span k+1
  localparam logic [OffW-1:0] SpanEdge [NumEdges] = '{
    9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
    9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
  };

  // floor(30.6001 * e)
  localparam logic [OffW-1:0] DayBase [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  typedef struct packed {
    logic                     func;
    logic signed [QuartW-1:0] quarter;
    logic [TermW-1:0]         mterm;
    logic [DayW-1:0]          day;
    logic [CycW-1:0]          cycle;
    logic [BaseW-1:0]         base;
  } jcdn_mid_t;

  // floor(30.6001 * (m + 1)) for the shifted month
  function automatic logic [TermW-1:0] month_term(input logic [4:0] m);
    logic [TermW-1:0] v;
    case (m)
      5'd3:    v = 9'd122;
      5'd4:    v = 9'd153;
      5'd5:    v = 9'd183;
      5'd6:    v = 9'd214;
      5'd7:    v = 9'd244;
      5'd8:    v = 9'd275;
      5'd9:    v = 9'd306;
      5'd10:   v = 9'd336;
      5'd11:   v = 9'd367;
      5'd12:   v = 9'd397;
      5'd13:   v = 9'd428;
      5'd14:   v = 9'd459;
      5'd15:   v = 9'd489;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(x / 30.6001) by threshold count
  function automatic logic [SpanW-1:0] span_of(input logic [OffW-1:0] x);
    logic [SpanW-1:0] n;
    n = '0;
    for (int k = 0; k < NumEdges; k++) begin
      if (x >= SpanEdge[k]) begin
        n = n + SpanW'(1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/jcdn_in_if.sv =====
// ----------------------------------------------------------------------------
// jcdn_in_if
// input channel: conversion request with valid/ready handshake
// ----------------------------------------------------------------------------
interface jcdn_in_if;
  import jcdn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [YearW-1:0] in_year;
  logic [MonthW-1:0]       in_month;
  logic [DayW-1:0]         in_day;
  logic [DnW-1:0]          in_day_number;

  modport source (
    output valid, func, in_year, in_month, in_day, in_day_number,
    input  ready
  );

  modport sink (
    input  valid, func, in_year, in_month, in_day, in_day_number,
    output ready
  );

endinterface

// ===== rtl/jcdn_out_if.sv =====
// ----------------------------------------------------------------------------
// jcdn_out_if
// output channel: conversion result with valid/ready handshake
// ----------------------------------------------------------------------------
interface jcdn_out_if;
  import jcdn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DnW-1:0]          out_day_number;
  logic signed [YearW-1:0] out_year;
  logic [MonthW-1:0]       out_month;
  logic [DayW-1:0]         out_day;

  modport source (
    output valid, out_day_number, out_year, out_month, out_day,
    input  ready
  );

  modport sink (
    input  valid, out_day_number, out_year, out_month, out_day,
    output ready
  );

endinterface

// ===== rtl/jcdn_front.sv =====
// ----------------------------------------------------------------------------
// jcdn_front
// input register, constant multiplies of both directions, middle register
// ----------------------------------------------------------------------------
module jcdn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  jcdn_in_if.sink             item_i,
  output logic                mid_valid_o,
  input  logic                mid_ready_i,
  output jcdn_pkg::jcdn_mid_t mid_o
);
  import jcdn_pkg::*;

  logic                    in_valid_q;
  logic                    func_q;
  logic signed [YearW-1:0] year_q;
  logic [MonthW-1:0]       month_q;
  logic [DayW-1:0]         day_q;
  logic [DnW-1:0]          dn_q;

  logic                    mid_valid_q;
  jcdn_mid_t               mid_q;
  jcdn_mid_t               mid_d;

  logic                    mid_free;
  logic                    in_free;

  logic                    not_pos;
  logic                    early;
  logic signed [16:0]      year_adj;
  logic signed [16:0]      year_off;
  logic signed [27:0]      year_prod;
  logic [4:0]              month_adj;
  logic [UW-1:0]           scaled;
  logic [ProdW-1:0]        recip_prod;

  assign mid_free    = !mid_valid_q || mid_ready_i;
  assign in_free     = !in_valid_q || mid_free;
  assign item_i.ready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && item_i.valid) begin
      func_q  <= item_i.func;
      year_q  <= item_i.in_year;
      month_q <= item_i.in_month;
      day_q   <= item_i.in_day;
      dn_q    <= item_i.in_day_number;
    end
  end

  // date to day number: year and month shift, then 365.25 * year
  always_comb begin
    not_pos  = year_q[YearW-1] || (year_q == '0);
    early    = (month_q <= MonthW'(2));
    year_adj = 17'(year_q) + (not_pos ? 17'sd1 : 17'sd0) - (early ? 17'sd1 : 17'sd0);
    month_adj = {1'b0, month_q} + (early ? 5'd12 : 5'd0);
    year_off = year_adj + 17'(YearBias);
    year_prod = 28'(year_off) * 28'sd1461;
  end

  // day number to date: cycle = floor((4 * (n + 1524) - 489) / 1461)
  always_comb begin
    scaled     = {1'b0, dn_q, 2'b00} + UW'(CycBias);
    recip_prod = ProdW'(scaled) * ProdW'(RecipMul);
  end

  always_comb begin
    mid_d.func    = func_q;
    mid_d.quarter = QuartW'(year_prod >>> 2);
    mid_d.mterm   = month_term(month_adj);
    mid_d.day     = day_q;
    mid_d.cycle   = recip_prod[RecipShift +: CycW];
    mid_d.base    = BaseW'(dn_q) + BaseW'(DnOffset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_free) begin
      mid_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_free && in_valid_q) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

endmodule

// ===== rtl/jcdn_back.sv =====
// ----------------------------------------------------------------------------
// jcdn_back
// final sums, span lookup, saturation and the result register
// ----------------------------------------------------------------------------
`include "julian_calendar_day_number_convert_top_macros.svh"

module jcdn_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_valid_i,
  output logic                mid_ready_o,
  input  jcdn_pkg::jcdn_mid_t mid_i,
  jcdn_out_if.source          result_o
);
  import jcdn_pkg::*;

  logic                    out_valid_q;
  logic                    func_q;
  logic [DnW-1:0]          dn_q,    dn_d;
  logic signed [YearW-1:0] year_q,  year_d;
  logic [MonthW-1:0]       month_q, month_d;
  logic [DayW-1:0]         day_q,   day_d;

  logic                    take;
  logic signed [26:0]      dn_sum;
  logic [DnW-1:0]          dn_sat;
  logic [25:0]             cyc_prod;
  logic [BaseW-1:0]        diff;
  logic [OffW-1:0]         offset;
  logic [SpanW-1:0]        span;
  logic [OffW-1:0]         dom;
  logic [MonthW-1:0]       mon;
  logic signed [16:0]      yr;
  logic signed [YearW-1:0] yr_sat;

  assign take        = !out_valid_q || result_o.ready;
  assign mid_ready_o = take;

  // date to day number
  always_comb begin
    dn_sum = 27'(mid_i.quarter)
           + 27'($signed({1'b0, mid_i.mterm}))
           + 27'($signed({1'b0, mid_i.day}))
           - 27'(DnOffset);
    if (dn_sum < 27'sd0) begin
      dn_sat = '0;
    end else if (dn_sum > 27'(DnMax)) begin
      dn_sat = DnW'(DnMax);
    end else begin
      dn_sat = dn_sum[DnW-1:0];
    end
  end

  // day number to date
  always_comb begin
    cyc_prod = 26'(mid_i.cycle) * 26'd1461;
    diff     = mid_i.base - cyc_prod[25:2];
    offset   = diff[OffW-1:0];
    span     = span_of(offset);
    dom      = offset - DayBase[span];
    mon      = (span < SpanW'(14)) ? (span - SpanW'(1)) : (span - SpanW'(13));
    yr       = 17'($signed({2'b00, mid_i.cycle}))
             - ((mon > MonthW'(2)) ? 17'(YearBias) : 17'(YearBias - 1));
    if (yr < 17'sd1) begin
      yr = yr - 17'sd1;
    end
    if (yr > 17'(YearMax)) begin
      yr_sat = YearW'(YearMax);
    end else if (yr < 17'(YearMin)) begin
      yr_sat = YearW'(YearMin);
    end else begin
      yr_sat = yr[YearW-1:0];
    end
  end

  always_comb begin
    if (mid_i.func) begin
      dn_d    = '0;
      year_d  = yr_sat;
      month_d = mon;
      day_d   = dom[DayW-1:0];
    end else begin
      dn_d    = dn_sat;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && mid_valid_i) begin
      func_q  <= mid_i.func;
      dn_q    <= dn_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.out_day_number = dn_q;
  assign result_o.out_year       = year_q;
  assign result_o.out_month      = month_q;
  assign result_o.out_day        = day_q;

  `JCDN_ASSERT(a_mid_to_out, clk_i, rst_ni, mid_valid_i && mid_ready_o |=> out_valid_q)
  `JCDN_ASSERT_IMPLY(a_date_fields, clk_i, rst_ni, out_valid_q && func_q, year_q != '0 && month_q >= 4'd1 && month_q <= 4'd12 && day_q != '0)
  `JCDN_ASSERT_IMPLY(a_number_zeros, clk_i, rst_ni, out_valid_q && !func_q, year_q == '0 && month_q == '0 && day_q == '0)

endmodule

// ===== rtl/julian_calendar_day_number_convert_top.sv =====
// ----------------------------------------------------------------------------
// julian_calendar_day_number_convert_top
// julian calendar date to julian day number and back, one beat per cycle
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    func, in_year, in_month, in_day, in_day_number
//   result_o  out  valid/ready    out_day_number, out_year, out_month, out_day
//
// one beat accepted per cycle unless stalled; input, middle, result registers
// the cycle divide and the date-side 365.25 multiply share the front stage
// asynchronous active-low reset empties all stages
// a stalled result holds; upstream stages keep filling until full
// ----------------------------------------------------------------------------
module julian_calendar_day_number_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  jcdn_in_if.sink     item_i,
  jcdn_out_if.source  result_o
);
  import jcdn_pkg::*;

  logic      mid_valid;
  logic      mid_ready;
  jcdn_mid_t mid;

  jcdn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  jcdn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .result_o    (result_o)
  );

endmodule

// ===== verif/jcdn_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// jcdn_tb_pkg
// operation codes shared by the converter testbench and its checker
// ----------------------------------------------------------------------------
package jcdn_tb_pkg;

  typedef enum logic {
    FuncToDayNumber = 1'b0,
    FuncToDate      = 1'b1
  } jcdn_func_e;

endpackage

// ===== verif/julian_calendar_day_number_convert_checker.sv =====
// ----------------------------------------------------------------------------
// julian_calendar_day_number_convert_checker
// Watches the request and result channels of the converter. Every accepted
// request is converted here with exact integer arithmetic and queued; every
// accepted result is compared field by field with the oldest queued value.
// ----------------------------------------------------------------------------
module julian_calendar_day_number_convert_checker (
  input  logic clk_i,
  input  logic rst_ni,
  jcdn_in_if   item_i,
  jcdn_out_if  result_i,
  output int   fail_count_o,
  output int   expected_left_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import jcdn_pkg::*;
  import jcdn_tb_pkg::*;

  typedef struct packed {
    logic [DnW-1:0]          day_number;
    logic signed [YearW-1:0] year;
    logic [MonthW-1:0]       month;
    logic [DayW-1:0]         day;
  } calendar_result_t;

  calendar_result_t converted_q[$];

  initial begin
    fail_count_o    = 0;
    expected_left_o = 0;
  end

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) begin
      q--;
    end
    return q;
  endfunction

  function automatic calendar_result_t convert_calendar(
    jcdn_func_e              f,
    logic signed [YearW-1:0] y,
    logic [MonthW-1:0]       m,
    logic [DayW-1:0]         d,
    logic [DnW-1:0]          n
  );
    calendar_result_t r;
    longint yr, mo, dd, nn, b, c, dq, e, v;
    r  = '0;
    yr = y;
    mo = m;
    dd = d;
    nn = n;
    if (f == FuncToDayNumber) begin
      if (yr < 1) begin
        yr++;
      end
      if (mo <= 2) begin
        yr--;
        mo += 12;
      end
      v = floor_quot(1461 * (yr + 4716), 4) + floor_quot(306001 * (mo + 1), 10000)
          + dd - 1524;
      if (v < 0) begin
        v = 0;
      end
      if (v > DnMax) begin
        v = DnMax;
      end
      r.day_number = DnW'(v);
    end else begin
      b  = nn + 1524;
      c  = floor_quot(20 * b - 2442, 7305);
      dq = floor_quot(1461 * c, 4);
      e  = floor_quot(10000 * (b - dq), 306001);
      mo = (e < 14) ? e - 1 : e - 13;
      yr = (mo > 2) ? c - 4716 : c - 4715;
      v  = b - dq - floor_quot(306001 * e, 10000);
      // no year zero
      if (yr < 1) begin
        yr--;
      end
      if (yr < YearMin) begin
        yr = YearMin;
      end
      if (yr > YearMax) begin
        yr = YearMax;
      end
      r.year  = YearW'(yr);
      r.month = MonthW'(mo);
      r.day   = DayW'(v);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    calendar_result_t want;
    if (!rst_ni) begin
      converted_q.delete();
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (converted_q.size() == 0) begin
          report_mismatch("result beat with nothing pending",
                          longint'(result_i.out_day_number), 0);
        end else begin
          want = converted_q.pop_front();
          if (result_i.out_day_number !== want.day_number) begin
            report_mismatch("out_day_number", longint'(result_i.out_day_number),
                            longint'(want.day_number));
          end
          if (result_i.out_year !== want.year) begin
            report_mismatch("out_year", longint'(result_i.out_year), longint'(want.year));
          end
          if (result_i.out_month !== want.month) begin
            report_mismatch("out_month", longint'(result_i.out_month),
                            longint'(want.month));
          end
          if (result_i.out_day !== want.day) begin
            report_mismatch("out_day", longint'(result_i.out_day), longint'(want.day));
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        converted_q.push_back(convert_calendar(jcdn_func_e'(item_i.func), item_i.in_year,
                                               item_i.in_month, item_i.in_day,
                                               item_i.in_day_number));
      end
    end
    expected_left_o = converted_q.size();
  end

endmodule

// ===== verif/julian_calendar_day_number_convert_top_tb.sv =====
// ----------------------------------------------------------------------------
// julian_calendar_day_number_convert_top_tb
// Drives date and day number conversion requests into the converter: a
// directed set of calendar edge cases, then random beats over both the
// legal ranges and the full field widths, with random stalls on both
// channels but in a quiet tail. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module julian_calendar_day_number_convert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jcdn_pkg::*;
  import jcdn_tb_pkg::*;

  localparam int RandomBeats = 950;
  localparam int QuietTail   = 150;
  localparam int CycleLimit  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic idling_on = 1'b1;
  int   fail_count;
  int   expected_left;
  int   cycle_count = 0;

  jcdn_in_if  item_if ();
  jcdn_out_if result_if ();

  julian_calendar_day_number_convert_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  julian_calendar_day_number_convert_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_if),
    .result_i        (result_if),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_request(
    jcdn_func_e              f,
    logic signed [YearW-1:0] y,
    logic [MonthW-1:0]       m,
    logic [DayW-1:0]         d,
    logic [DnW-1:0]          n
  );
    if (idling_on && $urandom_range(0, 6) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.func          <= f;
    item_if.in_year       <= y;
    item_if.in_month      <= m;
    item_if.in_day        <= d;
    item_if.in_day_number <= n;
    @(posedge clk_i);
    while (!item_if.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random();
    jcdn_func_e              f;
    logic signed [YearW-1:0] y;
    logic [MonthW-1:0]       m;
    logic [DayW-1:0]         d;
    logic [DnW-1:0]          n;
    f = jcdn_func_e'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      y = YearW'($urandom_range(0, 14711) - 4712);
      m = MonthW'($urandom_range(1, 12));
      d = DayW'($urandom_range(1, 31));
      n = DnW'($urandom_range(0, 5373600));
    end else begin
      y = YearW'($urandom);
      m = MonthW'($urandom);
      d = DayW'($urandom);
      n = DnW'($urandom);
    end
    send_request(f, y, m, d, n);
  endtask

  initial begin
    item_if.valid         = 1'b0;
    item_if.func          = FuncToDayNumber;
    item_if.in_year       = '0;
    item_if.in_month      = '0;
    item_if.in_day        = '0;
    item_if.in_day_number = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // date to day number: range ends, era change, leap day, odd inputs
    send_request(FuncToDayNumber, -4712, 1, 1, 5373600);
    send_request(FuncToDayNumber, 9999, 12, 31, 0);
    send_request(FuncToDayNumber, -1, 12, 31, 8388607);
    send_request(FuncToDayNumber, 1, 1, 1, 1);
    send_request(FuncToDayNumber, 0, 6, 15, 0);
    send_request(FuncToDayNumber, 4, 2, 29, 0);
    send_request(FuncToDayNumber, 4, 3, 1, 0);
    send_request(FuncToDayNumber, 2000, 0, 0, 0);
    send_request(FuncToDayNumber, 2000, 15, 31, 0);
    send_request(FuncToDayNumber, -16384, 1, 1, 0);
    send_request(FuncToDayNumber, 16383, 15, 31, 0);
    send_request(FuncToDayNumber, -4713, 1, 1, 0);
    // day number to date: zero, era change, range ends, saturation
    send_request(FuncToDate, -16384, 15, 31, 0);
    send_request(FuncToDate, 16383, 0, 0, 1);
    send_request(FuncToDate, 0, 0, 0, 1721423);
    send_request(FuncToDate, 0, 0, 0, 1721424);
    send_request(FuncToDate, 0, 0, 0, 1721057);
    send_request(FuncToDate, 0, 0, 0, 5373600);
    send_request(FuncToDate, 0, 0, 0, 8388607);
    send_request(FuncToDate, 0, 0, 0, 7700000);
    send_request(FuncToDate, 0, 0, 0, 2299160);
    send_request(FuncToDate, 0, 0, 0, 1462);

    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats / 2) begin
        item_if.valid <= 1'b0;
        wait (expected_left == 0);
        @(negedge clk_i);
      end
      if (i == RandomBeats - QuietTail) begin
        idling_on <= 1'b0;
      end
      send_random();
    end
    item_if.valid <= 1'b0;

    wait (expected_left == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jcdn_pkg.sv
rtl/jcdn_in_if.sv
rtl/jcdn_out_if.sv
rtl/jcdn_front.sv
rtl/jcdn_back.sv
rtl/julian_calendar_day_number_convert_top.sv
verif/jcdn_tb_pkg.sv
verif/julian_calendar_day_number_convert_checker.sv
verif/julian_calendar_day_number_convert_top_tb.sv
